### rtl/sic_pkg.sv
// Package for the system interrupt controller.
// Holds the transfer structs, command and register codes, and reset constants.
// Depends on nothing; every other file in the block imports it.
package sic_pkg;

  // Command codes carried in the input item.
  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_PIN   = 2'd2,
    CMD_NOP   = 2'd3
  } sic_cmd_e;

  // Register kinds produced by the offset decoder.
  typedef enum logic [2:0] {
    KIND_SWRST  = 3'd0,
    KIND_SYSCR  = 3'd1,
    KIND_RVECT  = 3'd2,
    KIND_MASK   = 3'd3,
    KIND_ASSIGN = 3'd4,
    KIND_STATUS = 3'd5,
    KIND_WAKEUP = 3'd6
  } sic_kind_e;

  // Register map layout.
  localparam logic [7:0] BANK_BASE      = 8'h0C;
  localparam logic [5:0] WITHIN_MASK    = 6'h00;
  localparam logic [5:0] WITHIN_STATUS  = 6'h14;
  localparam logic [5:0] WITHIN_WAKEUP  = 6'h18;
  localparam logic [5:0] WITHIN_LAST    = 6'h18;
  localparam logic [31:0] WAKEUP_RESET  = 32'hFFFF_FFFF;

  // One input item.
  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  offset;
    logic [31:0] write_data;
    logic [6:0]  pin;
    logic        level;
  } sic_in_t;

  // One result item.
  typedef struct packed {
    logic [31:0] read_data;
    logic [15:0] raise_levels;
  } sic_out_t;

  // Decoded register access.
  typedef struct packed {
    logic      hit;
    sic_kind_e kind;
    logic [1:0] bank;
    logic [1:0] sub;
  } sic_dec_t;

  // Reset value of each assignment word; words past the seventh reset to zero.
  function automatic logic [31:0] assign_reset_value(input int unsigned idx);
    logic [31:0] val;
    val = 32'h0000_0000;
    case (idx)
      1: val = 32'h1100_0000;
      2: val = 32'h3333_2222;
      3: val = 32'h4444_4433;
      4: val = 32'h5555_5555;
      5: val = 32'h0666_6655;
      6: val = 32'h3333_3000;
      default: val = 32'h0000_0000;
    endcase
    return val;
  endfunction

endpackage

### rtl/sic_decode.sv
// Register offset decoder for the system interrupt controller.
// Maps a byte offset to a register kind, bank and sub-index; uses sic_pkg.
module sic_decode import sic_pkg::*; #(
  parameter int unsigned NUM_BANKS = 2
) (
  input  logic [7:0] offset_i,
  output sic_dec_t   dec_o
);

  logic [7:0] rel;
  logic [5:0] bank_off;
  logic [2:0] word;

  assign rel      = offset_i - BANK_BASE;
  assign bank_off = rel[5:0];
  assign word     = bank_off[4:2];

  // Global registers sit below the first bank; banks repeat every 64 bytes.
  always_comb begin
    dec_o      = '0;
    dec_o.kind = KIND_SWRST;
    if (offset_i < BANK_BASE) begin
      dec_o.hit  = (offset_i[1:0] == 2'b00);
      dec_o.kind = sic_kind_e'({1'b0, offset_i[3:2]});
    end else begin
      dec_o.bank = rel[7:6];
      dec_o.hit  = ({1'b0, rel[7:6]} < 3'(NUM_BANKS)) && (bank_off[1:0] == 2'b00) &&
                   (bank_off <= WITHIN_LAST);
      if (bank_off == WITHIN_MASK) begin
        dec_o.kind = KIND_MASK;
      end else if (bank_off == WITHIN_STATUS) begin
        dec_o.kind = KIND_STATUS;
      end else if (bank_off == WITHIN_WAKEUP) begin
        dec_o.kind = KIND_WAKEUP;
      end else begin
        dec_o.kind = KIND_ASSIGN;
        dec_o.sub  = 2'(word - 3'd1);
      end
    end
  end

endmodule

### rtl/sic_forward.sv
// Interrupt forwarding logic for the system interrupt controller.
// Reduces pending, unmasked pins to a 16-bit raised level mask; uses sic_pkg.
module sic_forward import sic_pkg::*; #(
  parameter int unsigned NUM_BANKS = 2
) (
  input  logic [NUM_BANKS-1:0][31:0]   status_i,
  input  logic [NUM_BANKS-1:0][31:0]   mask_i,
  input  logic [NUM_BANKS*4-1:0][31:0] assign_i,
  output logic [15:0]                  raise_o
);

  // Each pending pin contributes the one-hot code of its assignment nibble.
  always_comb begin
    logic [31:0] pend;
    logic [3:0]  nib;
    raise_o = '0;
    for (int unsigned b = 0; b < NUM_BANKS; b++) begin
      pend = status_i[b] & mask_i[b];
      for (int unsigned p = 0; p < 32; p++) begin
        nib = assign_i[b * 4 + p / 8][(p % 8) * 4 +: 4];
        if (pend[p]) begin
          raise_o = raise_o | (16'd1 << nib);
        end
      end
    end
  end

endmodule

### rtl/sic_regs.sv
// Register file of the system interrupt controller: status, mask, assignment,
// wakeup and reset vector registers with read and update logic; uses sic_pkg.
module sic_regs import sic_pkg::*; #(
  parameter int unsigned NUM_BANKS = 2
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         fire_i,
  input  sic_in_t                      item_i,
  input  sic_dec_t                     dec_i,
  output logic [31:0]                  read_data_o,
  output logic                         fwd_o,
  output logic [NUM_BANKS-1:0][31:0]   status_d_o,
  output logic [NUM_BANKS-1:0][31:0]   mask_d_o,
  output logic [NUM_BANKS*4-1:0][31:0] assign_q_o
);

  logic [NUM_BANKS-1:0][31:0]   status_q, status_d;
  logic [NUM_BANKS-1:0][31:0]   mask_q, mask_d;
  logic [NUM_BANKS-1:0][31:0]   wakeup_q, wakeup_d;
  logic [NUM_BANKS*4-1:0][31:0] assign_q, assign_d;
  logic [15:0]                  rvect_q, rvect_d;
  logic                         pin_ok;
  sic_cmd_e                     cmd;

  assign cmd    = sic_cmd_e'(item_i.command);
  assign pin_ok = ({1'b0, item_i.pin} < 8'(NUM_BANKS * 32));

  // Next state and read data for the item in the input register.
  always_comb begin
    status_d    = status_q;
    mask_d      = mask_q;
    wakeup_d    = wakeup_q;
    assign_d    = assign_q;
    rvect_d     = rvect_q;
    read_data_o = '0;
    fwd_o       = 1'b0;
    case (cmd)
      CMD_READ: begin
        if (dec_i.hit) begin
          case (dec_i.kind)
            KIND_RVECT: read_data_o = {16'h0000, rvect_q};
            KIND_MASK, KIND_STATUS, KIND_WAKEUP: begin
              for (int unsigned b = 0; b < NUM_BANKS; b++) begin
                if (dec_i.bank == 2'(b)) begin
                  if (dec_i.kind == KIND_MASK) read_data_o = mask_q[b];
                  else if (dec_i.kind == KIND_STATUS) read_data_o = status_q[b];
                  else read_data_o = wakeup_q[b];
                end
              end
            end
            KIND_ASSIGN: begin
              for (int unsigned i = 0; i < NUM_BANKS * 4; i++) begin
                if ({dec_i.bank, dec_i.sub} == 4'(i)) read_data_o = assign_q[i];
              end
            end
            default: read_data_o = '0;
          endcase
        end
      end
      CMD_WRITE: begin
        if (dec_i.hit) begin
          case (dec_i.kind)
            KIND_RVECT: rvect_d = item_i.write_data[15:0];
            KIND_MASK: begin
              fwd_o = 1'b1;
              for (int unsigned b = 0; b < NUM_BANKS; b++) begin
                if (dec_i.bank == 2'(b)) mask_d[b] = item_i.write_data;
              end
            end
            KIND_WAKEUP: begin
              for (int unsigned b = 0; b < NUM_BANKS; b++) begin
                if (dec_i.bank == 2'(b)) wakeup_d[b] = item_i.write_data;
              end
            end
            KIND_ASSIGN: begin
              for (int unsigned i = 0; i < NUM_BANKS * 4; i++) begin
                if ({dec_i.bank, dec_i.sub} == 4'(i)) assign_d[i] = item_i.write_data;
              end
            end
            default: ;
          endcase
        end
      end
      CMD_PIN: begin
        if (pin_ok) begin
          fwd_o = 1'b1;
          for (int unsigned b = 0; b < NUM_BANKS; b++) begin
            if (item_i.pin[6:5] == 2'(b)) status_d[b][item_i.pin[4:0]] = item_i.level;
          end
        end
      end
      default: ;
    endcase
  end

  // State is committed when the item moves into the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q <= '0;
      mask_q   <= '0;
      rvect_q  <= '0;
      for (int unsigned b = 0; b < NUM_BANKS; b++) begin
        wakeup_q[b] <= WAKEUP_RESET;
      end
      for (int unsigned i = 0; i < NUM_BANKS * 4; i++) begin
        assign_q[i] <= assign_reset_value(i);
      end
    end else if (fire_i) begin
      status_q <= status_d;
      mask_q   <= mask_d;
      wakeup_q <= wakeup_d;
      assign_q <= assign_d;
      rvect_q  <= rvect_d;
    end
  end

  assign status_d_o = status_d;
  assign mask_d_o   = mask_d;
  assign assign_q_o = assign_q;

  // Status moves only on a pin change transfer.
  a_status_only_pin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(fire_i && (cmd == CMD_PIN)) |=> $stable(status_q))
    else $error("status changed without a pin change");

  // Masks move only on a register write transfer.
  a_mask_only_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(fire_i && (cmd == CMD_WRITE)) |=> $stable(mask_q))
    else $error("mask changed without a register write");

endmodule

### rtl/system_interrupt_controller.sv
// System interrupt controller, 32 pins per bank, levels reported as a mask.
// An item passes from the input register into the result register, and waits in the input
// register while the result register is full and stalled at the output.
// Throughput: one item per cycle through one update path, when the output does not stall.
// Reset: asynchronous, active low; clears status, masks and reset vector, sets
// wakeup words to all ones and assignment words to their default table.
module system_interrupt_controller import sic_pkg::*; #(
  parameter int unsigned NUM_BANKS = 2
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  sic_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output sic_out_t out_data_o
);

  sic_in_t                      in_q;
  logic                         in_valid_q;
  sic_out_t                     res_q, res_d;
  logic                         res_valid_q;
  logic                         res_ready;
  logic                         fire;
  sic_dec_t                     dec;
  logic [31:0]                  read_data;
  logic                         fwd;
  logic [NUM_BANKS-1:0][31:0]   status_d, mask_d;
  logic [NUM_BANKS*4-1:0][31:0] assign_q;
  logic [15:0]                  raise;

  // Handshake: the input register drains whenever the result register frees.
  assign res_ready  = !res_valid_q || !out_stall_i;
  assign fire       = in_valid_q && res_ready;
  assign in_stall_o = in_valid_q && !res_ready;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_data_i;
    end
  end

  sic_decode #(.NUM_BANKS(NUM_BANKS)) u_decode (
    .offset_i (in_q.offset),
    .dec_o    (dec)
  );

  sic_regs #(.NUM_BANKS(NUM_BANKS)) u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .item_i      (in_q),
    .dec_i       (dec),
    .read_data_o (read_data),
    .fwd_o       (fwd),
    .status_d_o  (status_d),
    .mask_d_o    (mask_d),
    .assign_q_o  (assign_q)
  );

  sic_forward #(.NUM_BANKS(NUM_BANKS)) u_forward (
    .status_i (status_d),
    .mask_i   (mask_d),
    .assign_i (assign_q),
    .raise_o  (raise)
  );

  // Result register.
  always_comb begin
    res_d.read_data    = read_data;
    res_d.raise_levels = fwd ? raise : 16'h0000;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (res_ready) begin
      res_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = res_valid_q;
  assign out_data_o  = res_q;

  // A result never carries both read data and raised levels.
  a_read_xor_raise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.read_data != 32'h0)) |-> (out_data_o.raise_levels == 16'h0))
    else $error("result carries read data and raised levels");

  // A held input item stays in place until the result register frees.
  a_input_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> (in_valid_q && $stable(in_q)))
    else $error("stalled input item was lost or changed");

endmodule
